// ===== rtl/core/cbda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbda_pkg: shared types and constants for the chain bend/dihedral block
// Fixed datapath widths, the sequencer phase type, the MAC control word and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cbda_pkg;

  // Parameter defaults
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Datapath widths fixed by the scaling scheme
  localparam int BOND_W    = 21;  // scaled bond / normal component, |v| < 2^20
  localparam int OPER_W    = 32;  // multiplier operand
  localparam int PROD_W    = 64;  // multiplier product
  localparam int ACC_W     = 68;  // accumulator
  localparam int M_W       = 43;  // cross product of two normals
  localparam int MH_SHIFT  = 21;  // split point of M for the triple product
  localparam int SQ_W      = 62;  // sum of squares
  localparam int CX_W      = 35;  // CORDIC x, y and z
  localparam int STEP_W    = 5;   // sequencer step counter
  localparam int TAB_IDX_W = 5;   // arctangent table index
  localparam int LIM_BOND  = 20;  // bond and normal scaling limit (bits)
  localparam int LIM_ANGLE = 30;  // atan2 operand scaling limit (bits)
  localparam int ZQ        = 30;  // CORDIC angle fraction bits

  // MAC sequence lengths
  localparam logic [3:0] MAC_N_CD    = 4'd9;  // cross product plus dot product
  localparam logic [3:0] MAC_N_CROSS = 4'd6;  // cross product only
  localparam logic [3:0] MAC_N_TRI   = 4'd6;  // triple product, split operand
  localparam logic [3:0] MAC_N_SQ    = 4'd3;  // sum of squares
  localparam logic [3:0] MAC_DOT0    = 4'd6;  // first dot term
  localparam logic [3:0] MAC_TRI_LO  = 4'd3;  // first low-half triple term

  localparam logic [1:0] LANE_DOT = 2'd3;

  localparam logic signed [CX_W-1:0] PI_HALF_Q30 = 35'sd1686629713;
  localparam logic signed [CX_W-1:0] PI_Q30      = 35'sd3373259426;

  typedef enum logic [4:0] {
    P_IDLE,
    P_SB_A,      // scale bond ba
    P_SB_B,      // scale bond bb
    P_SB_0,      // scale bond b0
    P_CHK,       // zero-bond check
    P_BEND_MAC,  // ba x bb and -(ba.bb)
    P_ASHR,      // scale atan2 operands
    P_SQ,        // sum of squares
    P_SQRT,      // integer square root
    P_CORDIC,    // atan2 vectoring
    P_N1_MAC,    // b0 x ba
    P_N1_SHR,
    P_N2_MAC,    // ba x bb
    P_N2_SHR,
    P_NCHK,      // zero-normal check
    P_M_MAC,     // n1 x n2 and n1.n2
    P_TRI,       // (n1 x n2).ba
    P_DONE
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       sub;
    logic       shl;
    logic       last;
    logic [1:0] dest;
  } mac_ctl_t;

  // atan(2^-i), 30 fraction bits, rounded to nearest
  function automatic logic [31:0] atan_q30(input logic [TAB_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048576;
      5'd11:   v = 32'd524288;
      5'd12:   v = 32'd262144;
      5'd13:   v = 32'd131072;
      5'd14:   v = 32'd65536;
      5'd15:   v = 32'd32768;
      5'd16:   v = 32'd16384;
      5'd17:   v = 32'd8192;
      5'd18:   v = 32'd4096;
      5'd19:   v = 32'd2048;
      5'd20:   v = 32'd1024;
      5'd21:   v = 32'd512;
      5'd22:   v = 32'd256;
      5'd23:   v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // next lane, modulo three
  function automatic logic [1:0] nxt3(input logic [1:0] k);
    logic [1:0] v;
    case (k)
      2'd0:    v = 2'd1;
      2'd1:    v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OPER_W-1:0] ext_bond(input logic signed [BOND_W-1:0] v);
    return {{(OPER_W - BOND_W){v[BOND_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/chain_bend_dihedral_angles.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_bend_dihedral_angles: bend and dihedral angles along a bead chain
// Keeps the last three beads of the current chain. From the third bead on,
// each item yields the bend angle at the middle bead; from the fourth bead
// on, also the signed dihedral. One shared multiplier, one scaling shifter,
// a bit-pair square root and a CORDIC stage work under a phase sequencer.
//
//   channel | signals                                     | dir
//   --------+---------------------------------------------+-----
//   in      | in_valid, in_ready, bead_x/y/z, new_chain   | in
//   out     | out_valid, out_ready, bend_angle,           | out
//           | dihedral_angle, dihedral_valid, degenerate  |
//
// Beads that yield no result leave the sequencer in idle. A result passes
// through the 4/1-bit scaling shifter for each vector, the shared MAC, the
// bit-pair square root and the CORDIC stage for each angle; a four-bead
// result repeats these for the dihedral. A zero bond or normal ends early.
// in_ready is high only in idle; a finished result waits in the output
// register, and a following result holds until that one is taken.
// Reset (rst, synchronous) empties the window and drops any pending result.
// ----------------------------------------------------------------------------
module chain_bend_dihedral_angles #(
  parameter int COORD_WIDTH  = cbda_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = cbda_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = cbda_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] bead_x,
  input  logic signed [COORD_WIDTH-1:0] bead_y,
  input  logic signed [COORD_WIDTH-1:0] bead_z,
  input  logic                          new_chain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ANGLE_WIDTH-2:0]        bend_angle,
  output logic signed [ANGLE_WIDTH-1:0] dihedral_angle,
  output logic                          dihedral_valid,
  output logic                          degenerate
);

  localparam int RB_W    = COORD_WIDTH + 1;
  localparam int SV_W    = (RB_W > 43) ? RB_W : 43;
  localparam int BOND_W  = cbda_pkg::BOND_W;
  localparam int OPER_W  = cbda_pkg::OPER_W;
  localparam int PROD_W  = cbda_pkg::PROD_W;
  localparam int ACC_W   = cbda_pkg::ACC_W;
  localparam int M_W     = cbda_pkg::M_W;
  localparam int MH_W    = M_W - cbda_pkg::MH_SHIFT;
  localparam int SQ_W    = cbda_pkg::SQ_W;
  localparam int CX_W    = cbda_pkg::CX_W;
  localparam int STEP_W  = cbda_pkg::STEP_W;
  localparam int AFRAC   = ANGLE_WIDTH - 3;
  localparam int ANG_SH  = cbda_pkg::ZQ - AFRAC;
  localparam logic signed [CX_W-1:0] ANG_RND = {{(CX_W - 1){1'b0}}, 1'b1} << (ANG_SH - 1);
  localparam logic [SQ_W-1:0] SQRT_BIT0 = {2'b01, {(SQ_W - 2){1'b0}}};

  // ---------------------------------------------------------------- state
  cbda_pkg::phase_t phase, phase_next;
  logic [STEP_W-1:0] step, step_next;
  logic [3:0]        mstep;

  logic [1:0] beads_seen, count_eff;
  logic       cnt3, deg, dih_pass, accept, out_free;

  logic signed [COORD_WIDTH-1:0] wx [3];
  logic signed [COORD_WIDTH-1:0] wy [3];
  logic signed [COORD_WIDTH-1:0] wz [3];

  logic signed [RB_W-1:0] rb_a [3];
  logic signed [RB_W-1:0] rb_b [3];
  logic signed [RB_W-1:0] rb_0 [3];

  logic signed [BOND_W-1:0] ba [3];
  logic signed [BOND_W-1:0] bb [3];
  logic signed [BOND_W-1:0] b0 [3];
  logic signed [BOND_W-1:0] n1s [3];
  logic signed [BOND_W-1:0] n2s [3];
  logic signed [M_W-1:0]    m_r [3];

  logic signed [SV_W-1:0] sv [4];

  // finished angles, held until the result register loads
  logic [ANGLE_WIDTH-2:0]        bend_r;
  logic signed [ANGLE_WIDTH-1:0] dih_r;
  logic                          dihedral_valid_r;

  // ---------------------------------------------------------------- handshake
  assign in_ready  = (phase == cbda_pkg::P_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign count_eff = new_chain ? 2'd0 : beads_seen;
  assign mstep     = step[3:0];

  // ---------------------------------------------------------------- scaling shifter
  logic [SV_W:0]          smag [4];
  logic [SV_W:0]          ssh  [4];
  logic [SV_W:0]          sres [4];
  logic signed [SV_W-1:0] shr_val [4];
  logic [SV_W:0]          orv;
  logic shr_hi, shr_big, shr_over, is_shr, shr_done;

  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      smag[i] = sv[i][SV_W-1] ? -{sv[i][SV_W-1], sv[i]} : {sv[i][SV_W-1], sv[i]};
      orv     = orv | smag[i];
    end
    shr_hi   = (phase == cbda_pkg::P_ASHR);
    shr_big  = shr_hi ? ((orv >> (cbda_pkg::LIM_ANGLE + 4)) != '0)
                      : ((orv >> (cbda_pkg::LIM_BOND + 4)) != '0);
    shr_over = shr_hi ? ((orv >> cbda_pkg::LIM_ANGLE) != '0)
                      : ((orv >> cbda_pkg::LIM_BOND) != '0);
    for (int i = 0; i < 4; i++) begin
      ssh[i]     = shr_big ? (smag[i] >> 4) : (smag[i] >> 1);
      sres[i]    = sv[i][SV_W-1] ? -ssh[i] : ssh[i];
      shr_val[i] = sres[i][SV_W-1:0];
    end
    is_shr = (phase == cbda_pkg::P_SB_A) || (phase == cbda_pkg::P_SB_B) ||
             (phase == cbda_pkg::P_SB_0) || (phase == cbda_pkg::P_N1_SHR) ||
             (phase == cbda_pkg::P_N2_SHR) || (phase == cbda_pkg::P_ASHR);
    shr_done = is_shr && (step != '0) && !shr_over;
  end

  // ---------------------------------------------------------------- MAC issue
  logic signed [OPER_W-1:0] va [3];
  logic signed [OPER_W-1:0] vb [3];
  logic signed [OPER_W-1:0] opa, opb;
  cbda_pkg::mac_ctl_t ictl, ctl_r;
  logic [3:0] mac_n, dsub, tsub;
  logic [1:0] ck, ci1, ci2, dk, tk;
  logic       is_mac, mac_done, is_cd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = cbda_pkg::ext_bond(ba[i]);
      vb[i] = cbda_pkg::ext_bond(bb[i]);
    end
    mac_n  = cbda_pkg::MAC_N_CD;
    is_mac = 1'b1;
    is_cd  = 1'b1;
    case (phase)
      cbda_pkg::P_BEND_MAC: mac_n = cbda_pkg::MAC_N_CD;
      cbda_pkg::P_N2_MAC:   mac_n = cbda_pkg::MAC_N_CROSS;
      cbda_pkg::P_N1_MAC: begin
        mac_n = cbda_pkg::MAC_N_CROSS;
        for (int i = 0; i < 3; i++) begin
          va[i] = cbda_pkg::ext_bond(b0[i]);
          vb[i] = cbda_pkg::ext_bond(ba[i]);
        end
      end
      cbda_pkg::P_M_MAC: begin
        mac_n = cbda_pkg::MAC_N_CD;
        for (int i = 0; i < 3; i++) begin
          va[i] = cbda_pkg::ext_bond(n1s[i]);
          vb[i] = cbda_pkg::ext_bond(n2s[i]);
        end
      end
      cbda_pkg::P_TRI: begin
        mac_n = cbda_pkg::MAC_N_TRI;
        is_cd = 1'b0;
      end
      cbda_pkg::P_SQ: begin
        mac_n = cbda_pkg::MAC_N_SQ;
        is_cd = 1'b0;
      end
      default: begin
        is_mac = 1'b0;
        is_cd  = 1'b0;
      end
    endcase
    mac_done = is_mac && (mstep == mac_n);

    ck   = mstep[2:1];
    ci1  = cbda_pkg::nxt3(ck);
    ci2  = cbda_pkg::nxt3(ci1);
    dsub = mstep - cbda_pkg::MAC_DOT0;
    dk   = dsub[1:0];
    tsub = mstep - cbda_pkg::MAC_TRI_LO;
    tk   = (mstep < cbda_pkg::MAC_TRI_LO) ? mstep[1:0] : tsub[1:0];

    opa  = '0;
    opb  = '0;
    ictl = '0;
    if (is_mac && (mstep < mac_n)) begin
      ictl.vld = 1'b1;
      if (is_cd && (mstep < cbda_pkg::MAC_DOT0)) begin
        // cross term: a[k+1]*b[k+2] - a[k+2]*b[k+1]
        opa       = mstep[0] ? va[ci2] : va[ci1];
        opb       = mstep[0] ? vb[ci1] : vb[ci2];
        ictl.clr  = !mstep[0];
        ictl.sub  = mstep[0];
        ictl.last = mstep[0];
        ictl.dest = ck;
      end else if (is_cd) begin
        // dot term, negated for the bend
        opa       = va[dk];
        opb       = vb[dk];
        ictl.clr  = (dk == 2'd0);
        ictl.sub  = (phase == cbda_pkg::P_BEND_MAC);
        ictl.last = (dk == 2'd2);
        ictl.dest = cbda_pkg::LANE_DOT;
      end else if (phase == cbda_pkg::P_TRI) begin
        // m = mh*2^21 + ml, each half times ba
        if (mstep < cbda_pkg::MAC_TRI_LO) begin
          opa      = {{(OPER_W - MH_W){m_r[tk][M_W-1]}}, m_r[tk][M_W-1:cbda_pkg::MH_SHIFT]};
          ictl.shl = 1'b1;
        end else begin
          opa = {{(OPER_W - cbda_pkg::MH_SHIFT){1'b0}}, m_r[tk][cbda_pkg::MH_SHIFT-1:0]};
        end
        opb       = cbda_pkg::ext_bond(ba[tk]);
        ictl.clr  = (mstep == 4'd0);
        ictl.last = (mstep == cbda_pkg::MAC_N_TRI - 4'd1);
      end else begin
        // sum of squares
        opa       = sv[mstep[1:0]][OPER_W-1:0];
        opb       = sv[mstep[1:0]][OPER_W-1:0];
        ictl.clr  = (mstep == 4'd0);
        ictl.last = (mstep == cbda_pkg::MAC_N_SQ - 4'd1);
      end
    end
  end

  // ---------------------------------------------------------------- MAC accumulate
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc, pe, acc_sum;
  logic trip_pos;

  always_comb begin
    pe = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (ctl_r.shl) begin
      pe = pe <<< cbda_pkg::MH_SHIFT;
    end
    acc_sum = (ctl_r.clr ? '0 : acc) + (ctl_r.sub ? -pe : pe);
  end

  // ---------------------------------------------------------------- square root and CORDIC
  logic [SQ_W-1:0] sq, sq_n, sq_r, sq_bit;
  logic [SQ_W:0]   sq_try;
  logic            sqrt_done;

  logic signed [CX_W-1:0] cx, cy, cz, cdx, cdy, ctab, cx0, cy0, zc, zr;
  logic [STEP_W-1:0]      cidx;
  logic [ANGLE_WIDTH-2:0] ang_u;
  logic signed [ANGLE_WIDTH-1:0] ang_s;
  logic cordic_done;

  always_comb begin
    sq_try    = {1'b0, sq_r} + {1'b0, sq_bit};
    sqrt_done = (phase == cbda_pkg::P_SQRT) && (step != '0) && (sq_bit == '0);

    cidx = step - STEP_W'(1);
    cdx  = cx >>> cidx;
    cdy  = cy >>> cidx;
    ctab = {{(CX_W - 32){1'b0}}, cbda_pkg::atan_q30(cidx[cbda_pkg::TAB_IDX_W-1:0])};
    cx0  = sv[3][CX_W-1:0];
    cy0  = {{(CX_W - 31){1'b0}}, sq_r[30:0]};
    cordic_done = (phase == cbda_pkg::P_CORDIC) && (step == STEP_W'(CORDIC_STEPS + 1));

    // clamp to [0, pi], round to the output grid
    if (cz < 0) begin
      zc = '0;
    end else if (cz > cbda_pkg::PI_Q30) begin
      zc = cbda_pkg::PI_Q30;
    end else begin
      zc = cz;
    end
    zr    = zc + ANG_RND;
    ang_u = zr[ANG_SH +: ANGLE_WIDTH - 1];
    ang_s = trip_pos ? -{1'b0, ang_u} : {1'b0, ang_u};
  end

  // ---------------------------------------------------------------- zero checks
  logic bonds_zero, norms_zero;

  always_comb begin
    bonds_zero = ((ba[0] == '0) && (ba[1] == '0) && (ba[2] == '0)) ||
                 ((bb[0] == '0) && (bb[1] == '0) && (bb[2] == '0)) ||
                 (cnt3 && (b0[0] == '0) && (b0[1] == '0) && (b0[2] == '0));
    norms_zero = ((n1s[0] == '0) && (n1s[1] == '0) && (n1s[2] == '0)) ||
                 ((n2s[0] == '0) && (n2s[1] == '0) && (n2s[2] == '0));
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    phase_next = phase;
    case (phase)
      cbda_pkg::P_IDLE:     if (accept && count_eff[1]) phase_next = cbda_pkg::P_SB_A;
      cbda_pkg::P_SB_A:     if (shr_done) phase_next = cbda_pkg::P_SB_B;
      cbda_pkg::P_SB_B:     if (shr_done) phase_next = cnt3 ? cbda_pkg::P_SB_0 : cbda_pkg::P_CHK;
      cbda_pkg::P_SB_0:     if (shr_done) phase_next = cbda_pkg::P_CHK;
      cbda_pkg::P_CHK:      phase_next = bonds_zero ? cbda_pkg::P_DONE : cbda_pkg::P_BEND_MAC;
      cbda_pkg::P_BEND_MAC: if (mac_done) phase_next = cbda_pkg::P_ASHR;
      cbda_pkg::P_ASHR:     if (shr_done) phase_next = cbda_pkg::P_SQ;
      cbda_pkg::P_SQ:       if (mac_done) phase_next = cbda_pkg::P_SQRT;
      cbda_pkg::P_SQRT:     if (sqrt_done) phase_next = cbda_pkg::P_CORDIC;
      cbda_pkg::P_CORDIC: begin
        if (cordic_done) begin
          phase_next = (dih_pass || !cnt3) ? cbda_pkg::P_DONE : cbda_pkg::P_N1_MAC;
        end
      end
      cbda_pkg::P_N1_MAC:   if (mac_done) phase_next = cbda_pkg::P_N1_SHR;
      cbda_pkg::P_N1_SHR:   if (shr_done) phase_next = cbda_pkg::P_N2_MAC;
      cbda_pkg::P_N2_MAC:   if (mac_done) phase_next = cbda_pkg::P_N2_SHR;
      cbda_pkg::P_N2_SHR:   if (shr_done) phase_next = cbda_pkg::P_NCHK;
      cbda_pkg::P_NCHK:     phase_next = norms_zero ? cbda_pkg::P_DONE : cbda_pkg::P_M_MAC;
      cbda_pkg::P_M_MAC:    if (mac_done) phase_next = cbda_pkg::P_TRI;
      cbda_pkg::P_TRI:      if (mac_done) phase_next = cbda_pkg::P_ASHR;
      cbda_pkg::P_DONE:     if (out_free) phase_next = cbda_pkg::P_IDLE;
      default:              phase_next = cbda_pkg::P_IDLE;
    endcase

    // step restarts on every phase change
    if (phase_next != phase) begin
      step_next = '0;
    end else if (is_shr || (phase == cbda_pkg::P_SQRT)) begin
      step_next = STEP_W'(1);
    end else if (is_mac || (phase == cbda_pkg::P_CORDIC)) begin
      step_next = step + STEP_W'(1);
    end else begin
      step_next = step;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cbda_pkg::P_IDLE;
      step       <= '0;
      beads_seen <= 2'd0;
      out_valid  <= 1'b0;
      ctl_r      <= '0;
    end else begin
      phase <= phase_next;
      step  <= step_next;
      ctl_r <= ictl;
      if (accept) begin
        beads_seen <= (count_eff == 2'd3) ? 2'd3 : count_eff + 2'd1;
      end
      if ((phase == cbda_pkg::P_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    // bead window and raw bonds
    if (accept) begin
      rb_a[0] <= {wx[1][COORD_WIDTH-1], wx[1]} - {wx[0][COORD_WIDTH-1], wx[0]};
      rb_a[1] <= {wy[1][COORD_WIDTH-1], wy[1]} - {wy[0][COORD_WIDTH-1], wy[0]};
      rb_a[2] <= {wz[1][COORD_WIDTH-1], wz[1]} - {wz[0][COORD_WIDTH-1], wz[0]};
      rb_b[0] <= {wx[0][COORD_WIDTH-1], wx[0]} - {bead_x[COORD_WIDTH-1], bead_x};
      rb_b[1] <= {wy[0][COORD_WIDTH-1], wy[0]} - {bead_y[COORD_WIDTH-1], bead_y};
      rb_b[2] <= {wz[0][COORD_WIDTH-1], wz[0]} - {bead_z[COORD_WIDTH-1], bead_z};
      rb_0[0] <= {wx[2][COORD_WIDTH-1], wx[2]} - {wx[1][COORD_WIDTH-1], wx[1]};
      rb_0[1] <= {wy[2][COORD_WIDTH-1], wy[2]} - {wy[1][COORD_WIDTH-1], wy[1]};
      rb_0[2] <= {wz[2][COORD_WIDTH-1], wz[2]} - {wz[1][COORD_WIDTH-1], wz[1]};
      wx[2] <= wx[1];  wy[2] <= wy[1];  wz[2] <= wz[1];
      wx[1] <= wx[0];  wy[1] <= wy[0];  wz[1] <= wz[0];
      wx[0] <= bead_x; wy[0] <= bead_y; wz[0] <= bead_z;
      cnt3     <= (count_eff == 2'd3);
      deg      <= 1'b0;
      dih_pass <= 1'b0;
      dihedral_valid_r <= 1'b0;
      dih_r    <= '0;
      bend_r   <= '0;
    end

    // scaling: load on the first step, then shift until in range
    if (is_shr && (step == '0)) begin
      for (int i = 0; i < 3; i++) begin
        case (phase)
          cbda_pkg::P_SB_A: sv[i] <= {{(SV_W - RB_W){rb_a[i][RB_W-1]}}, rb_a[i]};
          cbda_pkg::P_SB_B: sv[i] <= {{(SV_W - RB_W){rb_b[i][RB_W-1]}}, rb_b[i]};
          cbda_pkg::P_SB_0: sv[i] <= {{(SV_W - RB_W){rb_0[i][RB_W-1]}}, rb_0[i]};
          default:          sv[i] <= sv[i];
        endcase
      end
      if ((phase == cbda_pkg::P_SB_A) || (phase == cbda_pkg::P_SB_B) ||
          (phase == cbda_pkg::P_SB_0)) begin
        sv[3] <= '0;
      end
    end else if (is_shr && shr_over) begin
      for (int i = 0; i < 4; i++) begin
        sv[i] <= shr_val[i];
      end
    end

    if (shr_done) begin
      for (int i = 0; i < 3; i++) begin
        case (phase)
          cbda_pkg::P_SB_A:   ba[i]  <= sv[i][BOND_W-1:0];
          cbda_pkg::P_SB_B:   bb[i]  <= sv[i][BOND_W-1:0];
          cbda_pkg::P_SB_0:   b0[i]  <= sv[i][BOND_W-1:0];
          cbda_pkg::P_N1_SHR: n1s[i] <= sv[i][BOND_W-1:0];
          cbda_pkg::P_N2_SHR: n2s[i] <= sv[i][BOND_W-1:0];
          default:            ba[i]  <= ba[i];
        endcase
      end
    end

    // zero checks
    if ((phase == cbda_pkg::P_CHK) && bonds_zero) begin
      deg <= 1'b1;
    end
    if ((phase == cbda_pkg::P_NCHK) && norms_zero) begin
      deg <= 1'b1;
    end
    if (phase == cbda_pkg::P_NCHK) begin
      dih_pass <= 1'b1;
    end

    // cross-only jobs leave the dot lane empty
    if (((phase == cbda_pkg::P_N1_MAC) || (phase == cbda_pkg::P_N2_MAC)) && (step == '0)) begin
      sv[3] <= '0;
    end

    // multiply, then accumulate and write back
    prod_r <= opa * opb;
    if (ctl_r.vld) begin
      acc <= acc_sum;
      if (ctl_r.last) begin
        case (phase)
          cbda_pkg::P_TRI: trip_pos <= !acc_sum[ACC_W-1] && (acc_sum != '0);
          cbda_pkg::P_SQ:  sq <= acc_sum[SQ_W-1:0];
          default: begin
            sv[ctl_r.dest] <= acc_sum[SV_W-1:0];
            if ((phase == cbda_pkg::P_M_MAC) && (ctl_r.dest != cbda_pkg::LANE_DOT)) begin
              m_r[ctl_r.dest] <= acc_sum[M_W-1:0];
            end
          end
        endcase
      end
    end

    // square root, two bits of the radicand per step
    if (phase == cbda_pkg::P_SQRT) begin
      if (step == '0) begin
        sq_n   <= sq;
        sq_r   <= '0;
        sq_bit <= SQRT_BIT0;
      end else if (sq_bit != '0) begin
        if ({1'b0, sq_n} >= sq_try) begin
          sq_n <= sq_n - sq_try[SQ_W-1:0];
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
    end

    // CORDIC vectoring, one rotation per step
    if (phase == cbda_pkg::P_CORDIC) begin
      if (step == '0) begin
        if (cx0 < 0) begin
          cx <= cy0;
          cy <= -cx0;
          cz <= cbda_pkg::PI_HALF_Q30;
        end else begin
          cx <= cx0;
          cy <= cy0;
          cz <= '0;
        end
      end else if (!cordic_done) begin
        if (cy >= 0) begin
          cx <= cx + cdy;
          cy <= cy - cdx;
          cz <= cz + ctab;
        end else begin
          cx <= cx - cdy;
          cy <= cy + cdx;
          cz <= cz - ctab;
        end
      end else if (dih_pass) begin
        dih_r            <= ang_s;
        dihedral_valid_r <= 1'b1;
      end else begin
        bend_r <= ang_u;
      end
    end

    // result register
    if ((phase == cbda_pkg::P_DONE) && out_free) begin
      bend_angle     <= deg ? '0 : bend_r;
      dihedral_angle <= deg ? '0 : dih_r;
      dihedral_valid <= deg ? 1'b0 : dihedral_valid_r;
      degenerate     <= deg;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for chain_bend_dihedral_angles
// Feeds bead positions as chains (directed rows first, then random chains with
// zero, repeated and full-range steps) and checks every result in order
// against typed hand values or an in-bench fixed-point bend/dihedral model.
// ----------------------------------------------------------------------------
module tb;

  localparam int  N_RANDOM  = 2000;
  localparam int  DRAIN_CYC = 400;
  localparam int  HOLD_CYC  = 500;
  localparam longint PI_HALF = 64'sd1686629713;
  localparam longint PI_FULL = 64'sd3373259426;
  localparam longint ATAN_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768};

  typedef longint vec_t [4];

  typedef struct packed {
    logic [14:0]        bend;
    logic signed [15:0] dih;
    logic               dih_ok;
    logic               degen;
  } angles_t;

  typedef struct {
    bit                 nc;
    logic signed [31:0] x, y, z;
    bit                 typed;   // expectation given by hand
    bit                 yields;  // hand value: an item comes out
    angles_t            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] bead_x = '0, bead_y = '0, bead_z = '0;
  logic new_chain = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [14:0] bend_angle;
  logic signed [15:0] dihedral_angle;
  logic dihedral_valid, degenerate;

  chain_bend_dihedral_angles uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .bead_x(bead_x), .bead_y(bead_y), .bead_z(bead_z), .new_chain(new_chain),
    .out_valid(out_valid), .out_ready(out_ready),
    .bend_angle(bend_angle), .dihedral_angle(dihedral_angle),
    .dihedral_valid(dihedral_valid), .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: window of the last three beads, newest first
  longint win_x [3], win_y [3], win_z [3];
  int     beads_held;

  angles_t   angles_q [$];
  stim_row_t rows [$];
  int  n_err, n_results, n_dih, n_degen, n_items;
  bit  send_idle_on = 1'b1;

  // ---------------------------------------------------------------- predictor
  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // common truncating shift so all magnitudes fall below 2^bits
  function automatic void fit_bits(inout vec_t v, input int bits);
    longint mx;
    int s;
    mx = 0;
    s = 0;
    for (int i = 0; i < 4; i++) if (mag64(v[i]) > mx) mx = mag64(v[i]);
    while (s < 63 && (mx >> s) >= (64'sd1 << bits)) s++;
    for (int i = 0; i < 4; i++) v[i] = v[i] < 0 ? -(mag64(v[i]) >> s) : (v[i] >> s);
  endfunction

  function automatic vec_t cross_of(vec_t a, vec_t b);
    vec_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    o[3] = 0;
    return o;
  endfunction

  function automatic longint dot_of(vec_t a, vec_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic bit is_null(vec_t v);
    return v[0] == 0 && v[1] == 0 && v[2] == 0;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring CORDIC, y >= 0, angle in [0, pi] with 30 fraction bits
  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy, t;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = PI_HALF;
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x = x + dy; y = y - dx; z = z + ATAN_Q30[i];
      end else begin
        x = x - dy; y = y + dx; z = z - ATAN_Q30[i];
      end
    end
    if (z < 0) z = 0;
    if (z > PI_FULL) z = PI_FULL;
    return z;
  endfunction

  // angle from a cross vector and a dot product, Q3.13
  function automatic longint angle_q13(vec_t c, longint d);
    vec_t v;
    longint sq;
    v = c;
    v[3] = d;
    fit_bits(v, 30);
    sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    return (vector_angle(root_floor(sq), v[3]) + (64'sd1 << 16)) >>> 17;
  endfunction

  // advances the window; returns 1 when the bead yields an item
  function automatic bit next_angles(logic signed [31:0] x, y, z, bit nc,
                                     output angles_t r);
    vec_t ba, bb, b0, n1, n2, m;
    longint px, py, pz, bend, dih;
    bit deg, ok, has;
    int cnt;
    px = x; py = y; pz = z;
    cnt = beads_held;
    has = 1'b0;
    r = '0;
    bend = 0; dih = 0; ok = 1'b0;
    if (nc) begin
      for (int i = 0; i < 3; i++) begin
        win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
      end
      cnt = 0;
    end
    if (cnt >= 2) begin
      ba = '{win_x[1] - win_x[0], win_y[1] - win_y[0], win_z[1] - win_z[0], 0};
      bb = '{win_x[0] - px, win_y[0] - py, win_z[0] - pz, 0};
      fit_bits(ba, 20);
      fit_bits(bb, 20);
      deg = is_null(ba) || is_null(bb);
      if (cnt >= 3) begin
        b0 = '{win_x[2] - win_x[1], win_y[2] - win_y[1], win_z[2] - win_z[1], 0};
        fit_bits(b0, 20);
        deg = deg || is_null(b0);
      end
      if (!deg) bend = angle_q13(cross_of(ba, bb), -dot_of(ba, bb));
      if (cnt >= 3 && !deg) begin
        n1 = cross_of(b0, ba);
        n2 = cross_of(ba, bb);
        if (is_null(n1) || is_null(n2)) begin
          deg = 1'b1;
        end else begin
          fit_bits(n1, 20);
          fit_bits(n2, 20);
          m = cross_of(n1, n2);
          dih = angle_q13(m, dot_of(n1, n2));
          if (dot_of(m, ba) > 0) dih = -dih;
          ok = 1'b1;
        end
      end
      if (deg) begin
        bend = 0; dih = 0; ok = 1'b0;
      end
      r.bend = bend[14:0];
      r.dih = dih[15:0];
      r.dih_ok = ok;
      r.degen = deg;
      has = 1'b1;
    end
    win_x[2] = win_x[1]; win_y[2] = win_y[1]; win_z[2] = win_z[1];
    win_x[1] = win_x[0]; win_y[1] = win_y[0]; win_z[1] = win_z[0];
    win_x[0] = px; win_y[0] = py; win_z[0] = pz;
    beads_held = cnt >= 3 ? 3 : cnt + 1;
    return has;
  endfunction

  // ------------------------------------------------------------------ sender
  task automatic send_bead(stim_row_t row);
    angles_t a;
    bit has;
    while (send_idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    bead_x    <= row.x;
    bead_y    <= row.y;
    bead_z    <= row.z;
    new_chain <= row.nc;
    do @(posedge clk); while (!in_ready);
    has = next_angles(row.x, row.y, row.z, row.nc, a);
    if (row.typed) begin
      has = row.yields;
      a = row.want;
    end
    if (has) angles_q.push_back(a);
    n_items++;
  endtask

  function automatic void add_row(bit nc, logic signed [31:0] x, y, z,
                                  bit typed = 0, bit yields = 0, angles_t want = '0);
    stim_row_t r;
    r.nc = nc; r.x = x; r.y = y; r.z = z;
    r.typed = typed; r.yields = yields; r.want = want;
    rows.push_back(r);
  endfunction

  // ----------------------------------------------------------------- receiver
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    angles_t got, exp_a;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{bend_angle, dihedral_angle, dihedral_valid, degenerate};
        n_results++;
        if (angles_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("ERROR: item out with none expected: %p", got);
        end else begin
          exp_a = angles_q.pop_front();
          if (got.degen) n_degen++;
          if (got.dih_ok) n_dih++;
          if (got !== exp_a) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: item %0d: bend %0d/%0d dih %0d/%0d ok %b/%b deg %b/%b",
                       n_results, got.bend, exp_a.bend, got.dih, exp_a.dih,
                       got.dih_ok, exp_a.dih_ok, got.degen, exp_a.degen);
          end
        end
      end
      // one long hold-off after the hundredth result
      if (!hold_done && n_results == 100) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYC;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (n_results >= 200 && n_results < 300) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= $urandom_range(99) >= 17;
      end
    end
  end

  // ----------------------------------------------------------------- timeout
  initial begin
    #30_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // ----------------------------------------------------------------- stimulus
  initial begin
    stim_row_t r;
    angles_t zero_deg;
    logic signed [31:0] cx, cy, cz, sx, sy, sz;
    int left, mode, k, wait_cyc;
    n_err = 0; n_results = 0; n_dih = 0; n_degen = 0; n_items = 0;
    for (int i = 0; i < 3; i++) begin
      win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
    end
    beads_held = 0;
    zero_deg = '{15'd0, 16'sd0, 1'b0, 1'b1};

    // first two beads give nothing; zero bonds and a straight line are degenerate
    add_row(0, 0, 0, 0, 1, 0);
    add_row(0, 0, 0, 0, 1, 0);
    add_row(0, 32'sh10000, 0, 0, 1, 1, zero_deg);
    add_row(0, 32'sh20000, 0, 0, 1, 1, zero_deg);
    add_row(0, 32'sh30000, 0, 0, 1, 1, zero_deg);
    // coordinate extremes
    add_row(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0);
    add_row(0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0);
    add_row(0, 32'sh7fffffff, 32'sh80000000, 0);
    add_row(0, 0, 32'sh7fffffff, 32'sh80000000);
    add_row(0, 32'sh80000000, 0, 32'sh7fffffff);
    // right-angle chain: dihedrals of both signs, then a fold back
    add_row(1, 0, 0, 0);
    add_row(0, 32'sh10000, 0, 0);
    add_row(0, 32'sh10000, 32'sh10000, 0);
    add_row(0, 32'sh10000, 32'sh10000, 32'sh10000);
    add_row(0, 0, 32'sh10000, 32'sh10000);
    add_row(0, 0, 32'sh10000, 0);
    add_row(0, 0, 32'sh10000, 32'sh10000);
    // planar cis chain: zero triple product counts as positive
    add_row(1, 0, 0, 0);
    add_row(0, 1, 0, 0);
    add_row(0, 1, 1, 0);
    add_row(0, 0, 1, 0);
    add_row(0, -1, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_bead(rows[i]);

    // random chains
    left = 0;
    cx = 0; cy = 0; cz = 0; sx = 0; sy = 0; sz = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      send_idle_on = !(n >= 600 && n < 900);
      if (n == 1200) begin
        // sender pauses until every expected item is out
        in_valid <= 1'b0;
        while (angles_q.size() != 0) @(posedge clk);
      end
      r.typed = 0;
      r.nc = 0;
      if (left == 0) begin
        left = $urandom_range(1, 12);
        r.nc = 1;
        if ($urandom_range(3) == 0) begin
          cx = $urandom; cy = $urandom; cz = $urandom;
        end
      end
      left--;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        sx = 0; sy = 0; sz = 0;
      end else if (mode == 2) begin
        cx = $urandom; cy = $urandom; cz = $urandom;
        sx = 0; sy = 0; sz = 0;
      end else if (mode != 1) begin
        k = $urandom_range(1, 31);
        sx = $signed($urandom & ((32'd1 << k) - 1)) - $signed(32'd1 << (k - 1));
        sy = $signed($urandom & ((32'd1 << k) - 1)) - $signed(32'd1 << (k - 1));
        sz = $signed($urandom & ((32'd1 << k) - 1)) - $signed(32'd1 << (k - 1));
      end
      cx = cx + sx; cy = cy + sy; cz = cz + sz;
      r.x = cx; r.y = cy; r.z = cz;
      send_bead(r);
    end
    in_valid <= 1'b0;

    // drain, then allow for a late item
    wait_cyc = 0;
    while (angles_q.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (angles_q.size() != 0) begin
      n_err += angles_q.size();
      $display("ERROR: %0d expected items never came out", angles_q.size());
    end

    $display("tb: %0d beads sent, %0d angle items checked", n_items, n_results);
    $display("tb: %0d with a dihedral, %0d degenerate, %0d mismatches",
             n_dih, n_degen, n_err);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
